@@ rtl/snoise_pkg.sv @@
// Shared constants, types and functions of the simplex noise block.
// Holds fixed-point factors, the permutation table and the gradient dot helper.
// Depends on nothing.
`default_nettype none

package snoise_pkg;

    localparam int COORD_FRAC_BITS = 16;
    localparam int UP_SHIFT = 30 - COORD_FRAC_BITS;
    localparam int CELL_W = 35 - COORD_FRAC_BITS;
    localparam int SUM_W = 34;
    localparam int OFS_W = 34;
    localparam int D_W = 28;
    localparam int NCORN = 4;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam logic MODE_2D = 1'b0;
    localparam logic MODE_3D = 1'b1;

    localparam logic signed [29:0] SKEW2 = 30'sd393016785;
    localparam logic signed [29:0] UNSKEW2 = 30'sd226908346;
    localparam logic signed [29:0] SKEW3 = 30'sd357913941;
    localparam logic signed [29:0] UNSKEW3 = 30'sd178956971;
    localparam logic signed [OFS_W-1:0] ONE_Q30 = 34'sh040000000;
    localparam logic signed [34:0] FALL2 = 35'sd8388608;
    localparam logic signed [34:0] FALL3 = 35'sd10066330;

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91, 8'd90, 8'd15, 8'd131, 8'd13, 8'd201, 8'd95,
        8'd96, 8'd53, 8'd194, 8'd233, 8'd7, 8'd225, 8'd140, 8'd36, 8'd103, 8'd30,
        8'd69, 8'd142, 8'd8, 8'd99, 8'd37, 8'd240, 8'd21, 8'd10, 8'd23, 8'd190,
        8'd6, 8'd148, 8'd247, 8'd120, 8'd234, 8'd75, 8'd0, 8'd26, 8'd197, 8'd62,
        8'd94, 8'd252, 8'd219, 8'd203, 8'd117, 8'd35, 8'd11, 8'd32, 8'd57, 8'd177,
        8'd33, 8'd88, 8'd237, 8'd149, 8'd56, 8'd87, 8'd174, 8'd20, 8'd125, 8'd136,
        8'd171, 8'd168, 8'd68, 8'd175, 8'd74, 8'd165, 8'd71, 8'd134, 8'd139, 8'd48,
        8'd27, 8'd166, 8'd77, 8'd146, 8'd158, 8'd231, 8'd83, 8'd111, 8'd229, 8'd122,
        8'd60, 8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92, 8'd41, 8'd55, 8'd46,
        8'd245, 8'd40, 8'd244, 8'd102, 8'd143, 8'd54, 8'd65, 8'd25, 8'd63, 8'd161,
        8'd1, 8'd216, 8'd80, 8'd73, 8'd209, 8'd76, 8'd132, 8'd187, 8'd208, 8'd89,
        8'd18, 8'd169, 8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3, 8'd64, 8'd52, 8'd217,
        8'd226, 8'd250, 8'd124, 8'd123, 8'd5, 8'd202, 8'd38, 8'd147, 8'd118, 8'd126,
        8'd255, 8'd82, 8'd85, 8'd212, 8'd207, 8'd206, 8'd59, 8'd227, 8'd47, 8'd16,
        8'd58, 8'd17, 8'd182, 8'd189, 8'd28, 8'd42, 8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2, 8'd44, 8'd154, 8'd163, 8'd70, 8'd221, 8'd153,
        8'd101, 8'd155, 8'd167, 8'd43, 8'd172, 8'd9, 8'd129, 8'd22, 8'd39, 8'd253,
        8'd19, 8'd98, 8'd108, 8'd110, 8'd79, 8'd113, 8'd224, 8'd232, 8'd178, 8'd185,
        8'd112, 8'd104, 8'd218, 8'd246, 8'd97, 8'd228, 8'd251, 8'd34, 8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12, 8'd191, 8'd179, 8'd162, 8'd241, 8'd81, 8'd51,
        8'd145, 8'd235, 8'd249, 8'd14, 8'd239, 8'd107, 8'd49, 8'd192, 8'd214, 8'd31,
        8'd181, 8'd199, 8'd106, 8'd157, 8'd184, 8'd84, 8'd204, 8'd176, 8'd115, 8'd121,
        8'd50, 8'd45, 8'd127, 8'd4, 8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67, 8'd29, 8'd24, 8'd72, 8'd243, 8'd141, 8'd128, 8'd195,
        8'd78, 8'd66, 8'd215, 8'd61, 8'd156, 8'd180
    };

    typedef struct packed {
        logic                  live;
        logic signed [D_W-1:0] dx;
        logic signed [D_W-1:0] dy;
        logic signed [D_W-1:0] dz;
        logic [7:0]            hash;
    } t_corner;

    typedef struct packed {
        logic                   mode;
        t_corner [NCORN-1:0]    c;
    } t_job;

    function automatic logic signed [29:0] grad_dot(
        input logic [7:0] h,
        input logic signed [D_W-1:0] dx,
        input logic signed [D_W-1:0] dy,
        input logic signed [D_W-1:0] dz
    );
        logic [15:0] prod;
        logic [7:0] quo;
        logic [7:0] rem;
        logic signed [29:0] x;
        logic signed [29:0] y;
        logic signed [29:0] z;
        logic signed [29:0] r;
        prod = 16'(h) * 16'd171;
        quo = 8'(prod[15:11]);
        rem = h - 8'(quo * 8'd12);
        x = 30'(dx);
        y = 30'(dy);
        z = 30'(dz);
        case (rem[3:0])
            4'd0: r = x + y;
            4'd1: r = y - x;
            4'd2: r = x - y;
            4'd3: r = -x - y;
            4'd4: r = x + z;
            4'd5: r = z - x;
            4'd6: r = x - z;
            4'd7: r = -x - z;
            4'd8: r = y + z;
            4'd9: r = z - y;
            4'd10: r = y - z;
            4'd11: r = -y - z;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/snoise_if.sv @@
// Valid/ready channels of the simplex noise block: point in, noise out.
// Depends on nothing.
`default_nettype none

interface snoise_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    modport source(output valid, mode, coord_x, coord_y, coord_z, input ready);
    modport sink(input valid, mode, coord_x, coord_y, coord_z, output ready);
endinterface

interface snoise_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_value;
    modport source(output valid, noise_value, input ready);
    modport sink(input valid, noise_value, output ready);
endinterface

`default_nettype wire

@@ rtl/simplex_noise_2d_3d.sv @@
// Simplex noise, 2D and 3D: one point beat in, one Q1.15 noise beat out.
// Throughput: one point per cycle when nothing stalls; the front and back pipelines
// each take one item a cycle unless held by the side after them.
// A four-entry queue between them lets either side stall on its own.
// Reset: synchronous, active low; clears pipeline valid bits and queue pointers.
`default_nettype none

module simplex_noise_2d_3d (
    input  logic                i_clk,
    input  logic                i_rst_n,
    snoise_in_if.sink           i_point,
    snoise_out_if.source        o_noise
);
    import snoise_pkg::*;

    t_job f_job;
    t_job q_job;
    logic f_valid;
    logic f_ready;
    logic q_valid;
    logic q_ready;

    snoise_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_point.valid),
        .o_ready (i_point.ready),
        .i_mode  (i_point.mode),
        .i_x     (i_point.coord_x),
        .i_y     (i_point.coord_y),
        .i_z     (i_point.coord_z),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_job   (f_job)
    );

    snoise_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_job   (f_job),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_job   (q_job)
    );

    snoise_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_job   (q_job),
        .o_valid (o_noise.valid),
        .i_ready (o_noise.ready),
        .o_value (o_noise.noise_value)
    );

endmodule

`default_nettype wire

@@ rtl/snoise_front.sv @@
// Front pipeline: skew, cell floor, corner offsets, corner order and hashing.
// Depends on snoise_pkg.
`default_nettype none

module snoise_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_mode,
    input  logic signed [31:0] i_x,
    input  logic signed [31:0] i_y,
    input  logic signed [31:0] i_z,
    output logic               o_valid,
    input  logic               i_ready,
    output snoise_pkg::t_job   o_job
);
    import snoise_pkg::*;

    logic [8:0] r_fv;
    logic       f_en;

    logic                    r1_mode;
    logic signed [31:0]      r1_x, r1_y, r1_z;
    logic signed [SUM_W-1:0] r1_sum;
    logic signed [31:0]      n1_z;
    logic signed [SUM_W-1:0] n1_sum;

    logic               r2_mode;
    logic signed [31:0] r2_x, r2_y, r2_z;
    logic signed [63:0] r2_prod;
    logic signed [63:0] n2_prod;
    logic signed [29:0] n2_f;

    logic                     r3_mode;
    logic signed [31:0]       r3_x, r3_y, r3_z;
    logic signed [CELL_W-1:0] r3_i, r3_j, r3_k;
    logic signed [33:0]       n3_s;
    logic signed [34:0]       n3_xs, n3_ys, n3_zs;

    logic                     r4_mode;
    logic signed [31:0]       r4_x, r4_y, r4_z;
    logic signed [CELL_W-1:0] r4_i, r4_j, r4_k;
    logic signed [OFS_W-1:0]  r4_t;
    logic signed [CELL_W+1:0] n4_sum;
    logic signed [29:0]       n4_g;
    logic signed [CELL_W+31:0] n4_tp;

    logic                    r5_mode;
    logic signed [OFS_W-1:0] r5_x0, r5_y0, r5_z0;
    logic [7:0]              r5_i8, r5_j8, r5_k8;

    logic signed [OFS_W-1:0] n6_gs;
    logic signed [OFS_W-1:0] n6_ng [NCORN];
    logic [2:0]              n6_cb [NCORN];
    logic signed [OFS_W-1:0] n6_ex [NCORN];
    logic signed [OFS_W-1:0] n6_ey [NCORN];
    logic signed [OFS_W-1:0] n6_ez [NCORN];
    t_corner                 n6_c  [NCORN];
    logic [7:0]              n6_ka [NCORN];
    logic [7:0]              n6_kb [NCORN];
    logic [7:0]              n6_kc [NCORN];
    logic                    r6_mode;
    t_corner                 r6_c  [NCORN];
    logic [7:0]              r6_ka [NCORN];
    logic [7:0]              r6_kb [NCORN];
    logic [7:0]              r6_kc [NCORN];

    logic       r7_mode;
    t_corner    r7_c  [NCORN];
    logic [7:0] r7_ka [NCORN];
    logic [7:0] r7_kb [NCORN];
    logic [7:0] r7_h  [NCORN];

    logic       r8_mode;
    t_corner    r8_c  [NCORN];
    logic [7:0] r8_ka [NCORN];
    logic [7:0] r8_h  [NCORN];

    t_corner n9_c [NCORN];
    logic    r9_mode;
    t_corner r9_c [NCORN];

    assign f_en    = !r_fv[8] || i_ready;
    assign o_ready = f_en;
    assign o_valid = r_fv[8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= '0;
        end else if (f_en) begin
            r_fv <= {r_fv[7:0], i_valid};
        end
    end

    always_comb begin
        n1_z   = (i_mode == MODE_3D) ? i_z : '0;
        n1_sum = SUM_W'(i_x) + SUM_W'(i_y) + SUM_W'(n1_z);
        n2_f    = (r1_mode == MODE_3D) ? SKEW3 : SKEW2;
        n2_prod = r1_sum * n2_f;
        n3_s  = $signed(r2_prod[63:30]);
        n3_xs = 35'(r2_x) + 35'(n3_s);
        n3_ys = 35'(r2_y) + 35'(n3_s);
        n3_zs = 35'(r2_z) + 35'(n3_s);
        n4_sum = (CELL_W+2)'(r3_i) + (CELL_W+2)'(r3_j) + (CELL_W+2)'(r3_k);
        n4_g   = (r3_mode == MODE_3D) ? UNSKEW3 : UNSKEW2;
        n4_tp  = n4_sum * n4_g;
    end

    always_comb begin
        n6_gs = (r5_mode == MODE_3D) ? OFS_W'(UNSKEW3) : OFS_W'(UNSKEW2);
        n6_ng[0] = '0;
        n6_ng[1] = n6_gs;
        n6_ng[2] = n6_gs <<< 1;
        n6_ng[3] = n6_gs + (n6_gs <<< 1);
        n6_cb[0] = 3'b000;
        n6_cb[3] = 3'b111;
        if (r5_mode == MODE_2D) begin
            n6_cb[1] = (r5_x0 > r5_y0) ? 3'b100 : 3'b010;
            n6_cb[2] = 3'b110;
        end else if (r5_x0 >= r5_y0) begin
            if (r5_y0 >= r5_z0) begin
                n6_cb[1] = 3'b100;
                n6_cb[2] = 3'b110;
            end else if (r5_x0 >= r5_z0) begin
                n6_cb[1] = 3'b100;
                n6_cb[2] = 3'b101;
            end else begin
                n6_cb[1] = 3'b001;
                n6_cb[2] = 3'b101;
            end
        end else begin
            if (r5_y0 < r5_z0) begin
                n6_cb[1] = 3'b001;
                n6_cb[2] = 3'b011;
            end else if (r5_x0 < r5_z0) begin
                n6_cb[1] = 3'b010;
                n6_cb[2] = 3'b011;
            end else begin
                n6_cb[1] = 3'b010;
                n6_cb[2] = 3'b110;
            end
        end
        for (int n = 0; n < NCORN; n++) begin
            n6_ex[n] = r5_x0 - (n6_cb[n][2] ? ONE_Q30 : '0) + n6_ng[n];
            n6_ey[n] = r5_y0 - (n6_cb[n][1] ? ONE_Q30 : '0) + n6_ng[n];
            n6_ez[n] = r5_z0 - (n6_cb[n][0] ? ONE_Q30 : '0) + n6_ng[n];
            n6_c[n].live = (r5_mode == MODE_3D) || (n < NCORN - 1);
            n6_c[n].dx   = n6_ex[n][OFS_W-1:6];
            n6_c[n].dy   = n6_ey[n][OFS_W-1:6];
            n6_c[n].dz   = (r5_mode == MODE_3D) ? n6_ez[n][OFS_W-1:6] : '0;
            n6_c[n].hash = '0;
            n6_ka[n] = r5_i8 + 8'(n6_cb[n][2]);
            n6_kb[n] = r5_j8 + 8'(n6_cb[n][1]);
            n6_kc[n] = r5_k8 + 8'(n6_cb[n][0]);
        end
    end

    always_comb begin
        for (int n = 0; n < NCORN; n++) begin
            n9_c[n]      = r8_c[n];
            n9_c[n].hash = PERM[8'(r8_ka[n] + r8_h[n])];
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r1_mode <= i_mode;
            r1_x    <= i_x;
            r1_y    <= i_y;
            r1_z    <= n1_z;
            r1_sum  <= n1_sum;

            r2_mode <= r1_mode;
            r2_x    <= r1_x;
            r2_y    <= r1_y;
            r2_z    <= r1_z;
            r2_prod <= n2_prod;

            r3_mode <= r2_mode;
            r3_x    <= r2_x;
            r3_y    <= r2_y;
            r3_z    <= r2_z;
            r3_i    <= n3_xs[34:COORD_FRAC_BITS];
            r3_j    <= n3_ys[34:COORD_FRAC_BITS];
            r3_k    <= (r2_mode == MODE_3D) ? n3_zs[34:COORD_FRAC_BITS] : '0;

            r4_mode <= r3_mode;
            r4_x    <= r3_x;
            r4_y    <= r3_y;
            r4_z    <= r3_z;
            r4_i    <= r3_i;
            r4_j    <= r3_j;
            r4_k    <= r3_k;
            r4_t    <= n4_tp[OFS_W-1:0];

            r5_mode <= r4_mode;
            r5_x0   <= (OFS_W'(r4_x) <<< UP_SHIFT) - (OFS_W'(r4_i) <<< 30) + r4_t;
            r5_y0   <= (OFS_W'(r4_y) <<< UP_SHIFT) - (OFS_W'(r4_j) <<< 30) + r4_t;
            r5_z0   <= (OFS_W'(r4_z) <<< UP_SHIFT) - (OFS_W'(r4_k) <<< 30) + r4_t;
            r5_i8   <= r4_i[7:0];
            r5_j8   <= r4_j[7:0];
            r5_k8   <= r4_k[7:0];

            r6_mode <= r5_mode;
            r7_mode <= r6_mode;
            r8_mode <= r7_mode;
            r9_mode <= r8_mode;
            for (int n = 0; n < NCORN; n++) begin
                r6_c[n]  <= n6_c[n];
                r6_ka[n] <= n6_ka[n];
                r6_kb[n] <= n6_kb[n];
                r6_kc[n] <= n6_kc[n];

                r7_c[n]  <= r6_c[n];
                r7_ka[n] <= r6_ka[n];
                r7_kb[n] <= r6_kb[n];
                r7_h[n]  <= PERM[(r6_mode == MODE_3D) ? r6_kc[n] : r6_kb[n]];

                r8_c[n]  <= r7_c[n];
                r8_ka[n] <= r7_ka[n];
                r8_h[n]  <= (r7_mode == MODE_3D) ? PERM[8'(r7_kb[n] + r7_h[n])] : r7_h[n];

                r9_c[n]  <= n9_c[n];
            end
        end
    end

    always_comb begin
        o_job.mode = r9_mode;
        for (int n = 0; n < NCORN; n++) begin
            o_job.c[n] = r9_c[n];
        end
    end

endmodule

`default_nettype wire

@@ rtl/snoise_queue.sv @@
// Short job queue between the front and back pipelines.
// Depends on snoise_pkg.
`default_nettype none

module snoise_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  snoise_pkg::t_job i_job,
    output logic             o_valid,
    input  logic             i_ready,
    output snoise_pkg::t_job o_job
);
    import snoise_pkg::*;

    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    t_job              r_mem [QDEPTH];
    logic              push;
    logic              pop;

    assign o_ready = (r_cnt != QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({push, pop})
                2'b10: r_cnt <= r_cnt + 1'b1;
                2'b01: r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= QCNT_W'(QDEPTH))
        else $error("queue count beyond depth");
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("queue count missed a push");
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 1'b1))
        else $error("queue count missed a pop");
    a_empty_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("queue pointers disagree when empty");

endmodule

`default_nettype wire

@@ rtl/snoise_back.sv @@
// Back pipeline: corner falloff, gradient products, sum, scale and saturation.
// Depends on snoise_pkg.
`default_nettype none

module snoise_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  snoise_pkg::t_job   i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_value
);
    import snoise_pkg::*;

    logic [7:0] r_bv;
    logic       b_en;

    logic               r1_mode;
    logic [NCORN-1:0]   r1_live;
    logic signed [55:0] r1_sx  [NCORN];
    logic signed [55:0] r1_sy  [NCORN];
    logic signed [55:0] r1_sz  [NCORN];
    logic signed [29:0] r1_dot [NCORN];

    logic signed [57:0] n2_sum [NCORN];
    logic signed [34:0] n2_tt  [NCORN];
    logic signed [34:0] n2_lim;
    logic               r2_mode;
    logic [23:0]        r2_t   [NCORN];
    logic signed [29:0] r2_dot [NCORN];

    logic [47:0]        n3_p   [NCORN];
    logic               r3_mode;
    logic [23:0]        r3_t2  [NCORN];
    logic signed [29:0] r3_dot [NCORN];

    logic [47:0]        n4_p   [NCORN];
    logic               r4_mode;
    logic [23:0]        r4_t4  [NCORN];
    logic signed [29:0] r4_dot [NCORN];

    logic               r5_mode;
    logic signed [54:0] r5_term [NCORN];

    logic               r6_mode;
    logic signed [56:0] r6_acc;

    logic signed [63:0] n7_acc;
    logic signed [63:0] r7_sc;

    logic signed [30:0] n8_r;
    logic signed [15:0] n8_sat;
    logic signed [15:0] r_value;

    assign b_en    = !r_bv[7] || i_ready;
    assign o_ready = b_en;
    assign o_valid = r_bv[7];
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= '0;
        end else if (b_en) begin
            r_bv <= {r_bv[6:0], i_valid};
        end
    end

    always_comb begin
        n2_lim = (r1_mode == MODE_3D) ? FALL3 : FALL2;
        for (int n = 0; n < NCORN; n++) begin
            n2_sum[n] = 58'(r1_sx[n]) + 58'(r1_sy[n]) + 58'(r1_sz[n]);
            n2_tt[n]  = n2_lim - 35'(n2_sum[n][57:24]);
            n3_p[n]   = 48'(r2_t[n]) * 48'(r2_t[n]);
            n4_p[n]   = 48'(r3_t2[n]) * 48'(r3_t2[n]);
        end
        n7_acc = 64'(r6_acc);
        n8_r   = r7_sc[63:33];
        if (n8_r > 31'sd32767) begin
            n8_sat = 16'sh7fff;
        end else if (n8_r < -31'sd32768) begin
            n8_sat = 16'sh8000;
        end else begin
            n8_sat = n8_r[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r1_mode <= i_job.mode;
            r2_mode <= r1_mode;
            r3_mode <= r2_mode;
            r4_mode <= r3_mode;
            r5_mode <= r4_mode;
            r6_mode <= r5_mode;
            for (int n = 0; n < NCORN; n++) begin
                r1_live[n] <= i_job.c[n].live;
                r1_sx[n]   <= i_job.c[n].dx * i_job.c[n].dx;
                r1_sy[n]   <= i_job.c[n].dy * i_job.c[n].dy;
                r1_sz[n]   <= i_job.c[n].dz * i_job.c[n].dz;
                r1_dot[n]  <= grad_dot(i_job.c[n].hash, i_job.c[n].dx,
                                       i_job.c[n].dy, i_job.c[n].dz);

                r2_t[n]   <= (n2_tt[n][34] || !r1_live[n]) ? '0 : n2_tt[n][23:0];
                r2_dot[n] <= r1_dot[n];

                r3_t2[n]  <= n3_p[n][47:24];
                r3_dot[n] <= r2_dot[n];

                r4_t4[n]  <= n4_p[n][47:24];
                r4_dot[n] <= r3_dot[n];

                r5_term[n] <= $signed({1'b0, r4_t4[n]}) * r4_dot[n];
            end
            r6_acc <= 57'(r5_term[0]) + 57'(r5_term[1]) + 57'(r5_term[2])
                    + 57'(r5_term[3]);
            r7_sc  <= (r6_mode == MODE_3D) ? (n7_acc <<< 5)
                    : ((n7_acc <<< 6) + (n7_acc <<< 2) + (n7_acc <<< 1));
            r_value <= n8_sat;
        end
    end

endmodule

`default_nettype wire
